// File: hdl/assert_macros.svh
// Assertion helpers. Each module that asserts has clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define L3H_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");

// Checked at every edge, reset included.
`define L3H_ASSERT_NR(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("assertion failed");

`else

`define L3H_ASSERT(lbl, prop)
`define L3H_ASSERT_NR(lbl, prop)

`endif

`endif

// File: hdl/l3h_pkg.sv
`default_nettype none

package l3h_pkg;

	localparam int BLOCK_BYTES = 12;
	localparam logic [31:0] SEED_CONST = 32'hDEADBEEF;
	localparam logic [2:0] MIX_LAST_STEP = 3'd5;

	typedef logic [8*BLOCK_BYTES-1:0] blk_t;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} word3_t;

	// One command from the front to the back. Seeding and mixing never occur together.
	typedef struct packed {
		logic        seed_en;
		logic [31:0] seed;
		logic        mix_en;
		blk_t        mix_blk;
		logic        fin_en;
		logic        fin_empty;
		blk_t        fin_blk;
	} cmd_t;

	typedef struct packed {
		logic   empty;
		word3_t w;
	} fin_req_t;

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] k);
		return (x << k) | (x >> (6'd32 - {1'b0, k}));
	endfunction

	function automatic word3_t add_block(input word3_t w, input blk_t blk);
		word3_t r;
		r.a = w.a + blk[31:0];
		r.b = w.b + blk[63:32];
		r.c = w.c + blk[95:64];
		return r;
	endfunction

	function automatic word3_t mix_round(input word3_t w, input logic [2:0] step);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		word3_t r;
		a = w.a;
		b = w.b;
		c = w.c;
		unique case (step)
			3'd0: begin
				a = a - c; a = a ^ rotl32(c, 5'd4); c = c + b;
			end
			3'd1: begin
				b = b - a; b = b ^ rotl32(a, 5'd6); a = a + c;
			end
			3'd2: begin
				c = c - b; c = c ^ rotl32(b, 5'd8); b = b + a;
			end
			3'd3: begin
				a = a - c; a = a ^ rotl32(c, 5'd16); c = c + b;
			end
			3'd4: begin
				b = b - a; b = b ^ rotl32(a, 5'd19); a = a + c;
			end
			3'd5: begin
				c = c - b; c = c ^ rotl32(b, 5'd4); b = b + a;
			end
			default: begin
			end
		endcase
		r.a = a;
		r.b = b;
		r.c = c;
		return r;
	endfunction

	function automatic word3_t fin_round(input word3_t w, input logic [2:0] step);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		word3_t r;
		a = w.a;
		b = w.b;
		c = w.c;
		unique case (step)
			3'd0: begin
				c = c ^ b; c = c - rotl32(b, 5'd14);
			end
			3'd1: begin
				a = a ^ c; a = a - rotl32(c, 5'd11);
			end
			3'd2: begin
				b = b ^ a; b = b - rotl32(a, 5'd25);
			end
			3'd3: begin
				c = c ^ b; c = c - rotl32(b, 5'd16);
			end
			3'd4: begin
				a = a ^ c; a = a - rotl32(c, 5'd4);
			end
			3'd5: begin
				b = b ^ a; b = b - rotl32(a, 5'd14);
			end
			3'd6: begin
				c = c ^ b; c = c - rotl32(b, 5'd24);
			end
			default: begin
			end
		endcase
		r.a = a;
		r.b = b;
		r.c = c;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/l3h_front.sv
`default_nettype none

module l3h_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               byte_valid,
	input  wire logic               first,
	input  wire logic               last,
	input  wire logic [15:0]        name_length,
	input  wire logic               full,
	output logic                    push,
	output l3h_pkg::cmd_t           push_cmd
);

	localparam logic [3:0] FULL_CNT = 4'(l3h_pkg::BLOCK_BYTES);

	logic [7:0] buf_q [l3h_pkg::BLOCK_BYTES];
	logic [7:0] buf_n [l3h_pkg::BLOCK_BYTES];
	logic [3:0] cnt_q;
	logic [3:0] cnt0;
	logic [3:0] cnt1;
	logic [3:0] widx;
	logic       wrap;
	logic       accept;

	assign in_ready = !full;
	assign accept   = in_valid && !full;

	always_comb begin
		cnt0 = first ? 4'd0 : cnt_q;
		// A full block is mixed only once the next byte shows up.
		wrap = byte_valid && (cnt0 == FULL_CNT);
		widx = wrap ? 4'd0 : cnt0;
		if (!byte_valid) begin
			cnt1 = cnt0;
		end else if (wrap) begin
			cnt1 = 4'd1;
		end else begin
			cnt1 = cnt0 + 4'd1;
		end
		for (int i = 0; i < l3h_pkg::BLOCK_BYTES; i++) begin
			buf_n[i] = (byte_valid && widx == 4'(i)) ? data_byte : buf_q[i];
		end
	end

	always_comb begin
		push_cmd.seed_en   = first;
		push_cmd.seed      = {16'd0, name_length} + l3h_pkg::SEED_CONST;
		push_cmd.mix_en    = wrap;
		push_cmd.fin_en    = last;
		push_cmd.fin_empty = (cnt1 == 4'd0);
		for (int i = 0; i < l3h_pkg::BLOCK_BYTES; i++) begin
			push_cmd.mix_blk[8*i +: 8] = buf_q[i];
			push_cmd.fin_blk[8*i +: 8] = (4'(i) < cnt1) ? buf_n[i] : 8'd0;
		end
	end

	assign push = accept && (first || wrap || last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (accept) begin
			cnt_q <= last ? 4'd0 : cnt1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_q <= buf_n;
		end
	end

endmodule

`default_nettype wire

// File: hdl/l3h_fifo.sv
`default_nettype none

`include "assert_macros.svh"

module l3h_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire l3h_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output l3h_pkg::cmd_t      head,
	output logic               head_valid
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	l3h_pkg::cmd_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign full       = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	`L3H_ASSERT(a_no_push_full, push |-> !full)
	`L3H_ASSERT_NR(a_cnt_range, cnt_q <= CW'(DEPTH))

endmodule

`default_nettype wire

// File: hdl/l3h_back.sv
`default_nettype none

`include "assert_macros.svh"

module l3h_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire l3h_pkg::cmd_t head,
	input  wire logic          head_valid,
	output logic               pop,
	output logic               fin_valid,
	output l3h_pkg::fin_req_t  fin_req,
	input  wire logic          fin_ready
);

	l3h_pkg::word3_t words_q;
	l3h_pkg::word3_t eff;
	logic            busy_q;
	logic            mixed_q;
	logic [2:0]      step_q;
	logic            need_mix;
	logic            issue_ok;

	assign need_mix = head.mix_en && !mixed_q;

	always_comb begin
		if (head.seed_en) begin
			eff.a = head.seed;
			eff.b = head.seed;
			eff.c = head.seed;
		end else begin
			eff = words_q;
		end
	end

	assign issue_ok  = !busy_q && head_valid && !need_mix && (!head.fin_en || fin_ready);
	assign pop       = issue_ok;
	assign fin_valid = issue_ok && head.fin_en;

	always_comb begin
		fin_req.empty = head.fin_empty;
		fin_req.w     = l3h_pkg::add_block(eff, head.fin_blk);
	end

	// A mix first adds the block to the words, then applies one round per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_q <= '0;
			busy_q  <= 1'b0;
			mixed_q <= 1'b0;
			step_q  <= 3'd0;
		end else if (busy_q) begin
			words_q <= l3h_pkg::mix_round(words_q, step_q);
			if (step_q == l3h_pkg::MIX_LAST_STEP) begin
				busy_q  <= 1'b0;
				mixed_q <= 1'b1;
				step_q  <= 3'd0;
			end else begin
				step_q <= step_q + 3'd1;
			end
		end else if (head_valid && need_mix) begin
			words_q <= l3h_pkg::add_block(words_q, head.mix_blk);
			busy_q  <= 1'b1;
		end else if (issue_ok) begin
			words_q <= eff;
			mixed_q <= 1'b0;
		end
	end

	`L3H_ASSERT(a_busy_has_head, busy_q |-> head_valid)
	`L3H_ASSERT(a_mix_ends, busy_q && step_q == l3h_pkg::MIX_LAST_STEP |=> !busy_q && mixed_q)

endmodule

`default_nettype wire

// File: hdl/l3h_fin.sv
`default_nettype none

`include "assert_macros.svh"

module l3h_fin (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fin_valid,
	input  wire l3h_pkg::fin_req_t fin_req,
	output logic                   fin_ready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [63:0]            m_tdata
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic e_s1, e_s2, e_s3, e_s4, e_s5;
	l3h_pkg::word3_t w_s1, w_s2, w_s3, w_s4, w_s5;
	logic adv;

	// The whole pipeline moves together; it stalls only when the output word waits.
	assign adv       = !v_s5 || m_tready;
	assign fin_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= fin_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// An empty name skips the rounds and keeps its seeded words.
	always_ff @(posedge clk) begin
		if (adv) begin
			w_s1 <= fin_req.w;
			e_s1 <= fin_req.empty;
			w_s2 <= e_s1 ? w_s1 : l3h_pkg::fin_round(l3h_pkg::fin_round(w_s1, 3'd0), 3'd1);
			e_s2 <= e_s1;
			w_s3 <= e_s2 ? w_s2 : l3h_pkg::fin_round(l3h_pkg::fin_round(w_s2, 3'd2), 3'd3);
			e_s3 <= e_s2;
			w_s4 <= e_s3 ? w_s3 : l3h_pkg::fin_round(l3h_pkg::fin_round(w_s3, 3'd4), 3'd5);
			e_s4 <= e_s3;
			w_s5 <= e_s4 ? w_s4 : l3h_pkg::fin_round(w_s4, 3'd6);
			e_s5 <= e_s4;
		end
	end

	assign m_tvalid      = v_s5;
	assign m_tdata[31:0]  = e_s5 ? w_s5.c : w_s5.b;
	assign m_tdata[63:32] = e_s5 ? 32'd0 : w_s5.c;

	`L3H_ASSERT(a_issue_on_adv, fin_valid |-> fin_ready)

endmodule

`default_nettype wire

// File: hdl/lookup3_filename_hash64_unit.sv
`default_nettype none

// Streaming 64-bit lookup3 hash of a name, fed one byte per word. A byte word is
// taken every cycle while the command queue has room. Only words that start a name,
// end a name, or follow a full 12-byte block place a command in the queue. The block
// mixer handles each full block with an add step, six rounds and an issue step,
// which overlaps the arrival of the next block; the finish of each name takes an
// issue step in the mixer and then 5 pipeline stages. Names of any length, down to
// one byte, sustain one word per cycle, but a burst of short names arriving right
// behind a full-block mix can stall input once the queue fills. The queue depth sets
// how many commands (name starts, name ends and full blocks) may be outstanding
// before input stalls.
module lookup3_filename_hash64_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // data_byte[7:0], name_length[23:8]
	input  wire logic [1:0]  s_tuser,   // byte_valid[0], first[1]
	input  wire logic        s_tlast,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata    // hash_low[31:0], hash_high[63:32]
);

	logic                push;
	logic                full;
	logic                pop;
	logic                head_valid;
	logic                fin_valid;
	logic                fin_ready;
	l3h_pkg::cmd_t       push_cmd;
	l3h_pkg::cmd_t       head;
	l3h_pkg::fin_req_t   fin_req;

	l3h_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.data_byte   (s_tdata[7:0]),
		.byte_valid  (s_tuser[0]),
		.first       (s_tuser[1]),
		.last        (s_tlast),
		.name_length (s_tdata[23:8]),
		.full        (full),
		.push        (push),
		.push_cmd    (push_cmd)
	);

	l3h_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	l3h_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.fin_valid  (fin_valid),
		.fin_req    (fin_req),
		.fin_ready  (fin_ready)
	);

	l3h_fin u_fin (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_valid (fin_valid),
		.fin_req   (fin_req),
		.fin_ready (fin_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

`default_nettype wire
